// ===== rtl/sorted_key_table_floor_search_defines.svh =====
// Assertion macros used by the table RTL.
`ifndef SORTED_KEY_TABLE_FLOOR_SEARCH_DEFINES_SVH
`define SORTED_KEY_TABLE_FLOOR_SEARCH_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SKFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SKFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/skfs_pkg.sv =====
`default_nettype none

package skfs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    localparam int IN_FIELDS_W  = KEY_BITS + HANDLE_BITS + POS_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = POS_W + KEY_BITS + HANDLE_BITS + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RM_HANDLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RM_AT     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLOOR     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_AT   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/sorted_key_table_floor_search.sv =====
`default_nettype none
// Channel   Direction  Payload
// s_*       in         tuser: req_type; tdata: key_in, handle_in, position_in
// m_*       out        tuser: status; tdata: position_out, key_out, handle_out,
//                      entry_count
// One request is taken at a time; s_tready is high only while the sequencer is idle.
// Read at index fetches a single entry; floor search, insert and removal walk the
// table one entry per cycle over the single table port, with one shared comparator.
// Reset clears the fill count and control state; the table contents are not cleared.
// A result waits in the final state while the output register holds an unaccepted transfer.
`include "sorted_key_table_floor_search_defines.svh"

module sorted_key_table_floor_search
    import skfs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // key_in [31:0], handle_in [47:32], position_in [55:48]
    input  wire logic [IN_DATA_W-1:0]    s_tdata,
    // req_type [2:0]
    input  wire logic [REQ_W-1:0]        s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // position_out [7:0], key_out [39:8], handle_out [55:40], entry_count [64:56],
    // zero fill [71:65]
    output logic [OUT_DATA_W-1:0]        m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]          m_tuser
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SHIFT_UP = 3'd2;
    localparam logic [2:0] ST_SHIFT_DN = 3'd3;
    localparam logic [2:0] ST_FETCH    = 3'd4;
    localparam logic [2:0] ST_CAPT     = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [REQ_W-1:0]              req_reg, req_next;
    logic signed [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0]        handle_reg, handle_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              widx_reg, widx_next;
    logic [CNT_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic                          dv_reg, dv_next;
    logic [STATUS_W-1:0]           res_status_reg, res_status_next;
    logic signed [KEY_BITS-1:0]    res_key_reg, res_key_next;
    logic [HANDLE_BITS-1:0]        res_handle_reg, res_handle_next;
    logic [CNT_W-1:0]              res_pos_reg, res_pos_next;
    logic                          m_valid_reg;
    logic [OUT_DATA_W-1:0]         m_data_reg;
    logic [STATUS_W-1:0]           m_user_reg;

    logic [KEY_BITS-1:0]           key_mem [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0]        handle_mem [TABLE_DEPTH];
    logic signed [KEY_BITS-1:0]    rd_key_reg;
    logic [HANDLE_BITS-1:0]        rd_handle_reg;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [KEY_BITS-1:0]           mem_wkey;
    logic [HANDLE_BITS-1:0]        mem_whandle;

    logic                          load_out;
    logic [CNT_W-1:0]              pos_in_ext;
    logic [CNT_W-1:0]              idx_dec;
    logic [CNT_W-1:0]              idx_inc;
    logic [CNT_W-1:0]              n_inc;
    logic [CNT_W-1:0]              cmp_dec;
    logic [CNT_W-1:0]              fill_dec;
    logic                          key_lt;
    logic                          key_eq;
    logic                          handle_eq;
    logic                          scan_hit;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_user_reg;

    assign pos_in_ext = CNT_W'(s_tdata[KEY_BITS+HANDLE_BITS +: POS_W]);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign n_inc      = n_reg + CNT_W'(1);
    assign cmp_dec    = cmp_idx_reg - CNT_W'(1);
    assign fill_dec   = fill_reg - CNT_W'(1);

    // Shared comparator on the entry just read from the table.
    assign key_lt     = rd_key_reg < key_reg;
    assign key_eq     = rd_key_reg == key_reg;
    assign handle_eq  = rd_handle_reg == handle_reg;

    always_comb
    begin
        case (req_reg)
            REQ_INSERT:    scan_hit = !key_lt;
            REQ_FLOOR:     scan_hit = !key_lt && !key_eq;
            REQ_RM_HANDLE: scan_hit = handle_eq;
            default:       scan_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr]    <= mem_wkey;
            handle_mem[mem_waddr] <= mem_whandle;
        end
        if (mem_re)
        begin
            rd_key_reg    <= key_mem[mem_raddr];
            rd_handle_reg <= handle_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        widx_next       = widx_reg;
        cmp_idx_next    = cmp_idx_reg;
        n_next          = n_reg;
        dv_next         = dv_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_handle_next = res_handle_reg;
        res_pos_next    = res_pos_reg;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[ADDR_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = widx_reg[ADDR_W-1:0];
        mem_wkey        = rd_key_reg;
        mem_whandle     = rd_handle_reg;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = s_tuser;
                    key_next        = s_tdata[KEY_BITS-1:0];
                    handle_next     = s_tdata[KEY_BITS +: HANDLE_BITS];
                    n_next          = pos_in_ext;
                    idx_next        = '0;
                    dv_next         = 1'b0;
                    res_status_next = STAT_NOT_FOUND;
                    res_key_next    = '0;
                    res_handle_next = '0;
                    res_pos_next    = '0;
                    case (s_tuser)
                        REQ_INSERT:
                        begin
                            if (fill_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_RM_HANDLE, REQ_FLOOR:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_RM_AT, REQ_READ_AT:
                        begin
                            if (pos_in_ext < fill_reg)
                            begin
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (dv_reg && scan_hit)
                begin
                    dv_next = 1'b0;
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            n_next     = cmp_idx_reg;
                            idx_next   = fill_reg;
                            state_next = ST_SHIFT_UP;
                        end
                        REQ_FLOOR:
                        begin
                            if (cmp_idx_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                n_next     = cmp_dec;
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            n_next     = cmp_idx_reg;
                            state_next = ST_FETCH;
                        end
                    endcase
                end
                else if (!dv_reg && (idx_reg >= fill_reg))
                begin
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            n_next     = fill_reg;
                            idx_next   = fill_reg;
                            state_next = ST_SHIFT_UP;
                        end
                        REQ_FLOOR:
                        begin
                            if (fill_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                n_next     = fill_dec;
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else if (idx_reg < fill_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = idx_reg[ADDR_W-1:0];
                    dv_next      = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_inc;
                end
                else
                begin
                    dv_next = 1'b0;
                end
            end

            ST_SHIFT_UP:
            begin
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = widx_reg[ADDR_W-1:0];
                end
                if (idx_reg > n_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec[ADDR_W-1:0];
                    widx_next = idx_reg;
                    idx_next  = idx_dec;
                    dv_next   = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = n_reg[ADDR_W-1:0];
                        mem_wkey        = key_reg;
                        mem_whandle     = handle_reg;
                        fill_next       = fill_reg + CNT_W'(1);
                        res_status_next = STAT_OK;
                        res_key_next    = key_reg;
                        res_handle_next = handle_reg;
                        res_pos_next    = n_reg;
                        state_next      = ST_FINISH;
                    end
                end
            end

            ST_FETCH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = n_reg[ADDR_W-1:0];
                state_next = ST_CAPT;
            end

            ST_CAPT:
            begin
                res_status_next = STAT_OK;
                res_key_next    = rd_key_reg;
                res_handle_next = rd_handle_reg;
                res_pos_next    = n_reg;
                if ((req_reg == REQ_RM_HANDLE) || (req_reg == REQ_RM_AT))
                begin
                    idx_next   = n_inc;
                    dv_next    = 1'b0;
                    state_next = ST_SHIFT_DN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_SHIFT_DN:
            begin
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = widx_reg[ADDR_W-1:0];
                end
                if (idx_reg < fill_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[ADDR_W-1:0];
                    widx_next = idx_dec;
                    idx_next  = idx_inc;
                    dv_next   = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        fill_next  = fill_dec;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            dv_reg    <= dv_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        idx_reg        <= idx_next;
        widx_reg       <= widx_next;
        cmp_idx_reg    <= cmp_idx_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_handle_reg <= res_handle_next;
        res_pos_reg    <= res_pos_next;
        if (load_out)
        begin
            m_user_reg <= res_status_reg;
            m_data_reg <= {{OUT_PAD_W{1'b0}}, COUNT_W'(fill_reg), res_handle_reg,
                           res_key_reg, POS_W'(res_pos_reg)};
        end
    end

    `SKFS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(TABLE_DEPTH),
        "fill count beyond table depth")
    `SKFS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "second request taken while busy")
    `SKFS_ASSERT_NEXT(a_idle_fill_stable, state_reg == ST_IDLE, $stable(fill_reg),
        "fill count changed while idle")
    `SKFS_ASSERT_NOW(a_error_payload_zero, m_valid_reg && (m_user_reg != STAT_OK),
        m_data_reg[POS_W+KEY_BITS+HANDLE_BITS-1:0] == '0,
        "failed request carries entry data")

endmodule

`default_nettype wire
